[rtl/core/cbm_pkg.sv]
// shared types and constants for the cartridge bank mapper
`timescale 1ns / 1ps

package cbm_pkg;

   localparam int CHR_SLOTS_DEF = 8;

   localparam logic [15:0] IRQ_LIMIT  = 16'd209;
   localparam logic [4:0]  PRG_FIXED0 = 5'h1E;
   localparam logic [4:0]  PRG_FIXED1 = 5'h1F;
   localparam logic [7:0]  MIRROR_IGNORE = 8'hFF;

   // register indexes of the configuration port
   localparam logic CSR_CHR_RAM_MODE = 1'b0;
   localparam logic CSR_CHR_SHIFT    = 1'b1;

   // top nibble of the folded write address
   localparam logic [3:0] NIB_PRG0 = 4'h8;
   localparam logic [3:0] NIB_CTRL = 4'h9;
   localparam logic [3:0] NIB_PRG1 = 4'hA;
   localparam logic [3:0] NIB_CHR0 = 4'hB;
   localparam logic [3:0] NIB_CHR3 = 4'hE;
   localparam logic [3:0] NIB_IRQ  = 4'hF;
   localparam logic [1:0] LOW_IRQ_ARM = 2'd2;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_TICK  = 2'd1,
      OP_PRG   = 2'd2,
      OP_CHR   = 2'd3
   } op_type;

   typedef struct packed {
      op_type      operation;
      logic [15:0] address;
      logic [7:0]  data;
      logic [7:0]  cycles;
      logic        visible_line;
   } req_type;

   typedef struct packed {
      logic [8:0] bank;
      logic [1:0] mirror_mode;
      logic       irq_line;
   } rsp_type;

   typedef struct packed {
      logic        chr_ram_mode;
      logic        chr_shift;
      logic        prg_swap;
      logic [1:0]  mirror;
      logic        outer_bank;
      logic [4:0]  prg0;
      logic [4:0]  prg1;
      logic        irq_enable;
      logic [15:0] irq_count;
      logic        irq_pending;
   } map_state_type;

endpackage

[rtl/core/cartridge_bank_mapper_irq_core.sv]
// top level of the cartridge bank mapper with cycle counting irq
// a request beat passes the input register, then the result register, to the response
// one beat per cycle when not stalled; state updates as a beat leaves the input reg
// response stall holds the result register and backs up into the input register
// synchronous reset: bank registers zero, outer bank one, irq disarmed, pipeline empty
`timescale 1ns / 1ps

module cartridge_bank_mapper_irq_core #(
   parameter int CHR_SLOTS = cbm_pkg::CHR_SLOTS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  cbm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cbm_pkg::rsp_type rsp_data,
   input  logic             csr_write,
   input  logic             csr_index,
   input  logic             csr_wdata
);

   logic             in_valid_ff, in_valid_in;
   cbm_pkg::req_type in_item_ff;
   logic             out_valid_ff, out_valid_in;
   cbm_pkg::rsp_type out_data_ff;

   logic out_free, fire, accept;
   logic [8:0] bank;

   cbm_pkg::map_state_type    cur, nxt;
   logic [CHR_SLOTS-1:0][7:0] chr_low;
   logic [CHR_SLOTS-1:0]      chr_high;

   assign out_free     = !out_valid_ff || !rsp_stall;
   assign fire         = in_valid_ff && out_free;
   assign req_stall    = in_valid_ff && !out_free;
   assign accept       = req_valid && !req_stall;
   assign in_valid_in  = accept || (in_valid_ff && !fire);
   assign out_valid_in = fire || (out_valid_ff && rsp_stall);

   cbm_regs #(.CHR_SLOTS(CHR_SLOTS)) u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .fire      (fire),
      .item      (in_item_ff),
      .cur       (cur),
      .nxt       (nxt),
      .chr_low   (chr_low),
      .chr_high  (chr_high)
   );

   cbm_lookup #(.CHR_SLOTS(CHR_SLOTS)) u_lookup (
      .item     (in_item_ff),
      .cur      (cur),
      .chr_low  (chr_low),
      .chr_high (chr_high),
      .bank     (bank)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff <= req_data;
      end
      // mirroring and irq are reported as they stand after this beat
      if (fire) begin
         out_data_ff.bank        <= bank;
         out_data_ff.mirror_mode <= nxt.mirror;
         out_data_ff.irq_line    <= nxt.irq_pending;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

[rtl/core/cbm_regs.sv]
// mapper registers: write decode, irq counter and configuration
`timescale 1ns / 1ps

module cbm_regs #(
   parameter int CHR_SLOTS = cbm_pkg::CHR_SLOTS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic                   csr_index,
   input  logic                   csr_wdata,
   input  logic                   fire,
   input  cbm_pkg::req_type       item,
   output cbm_pkg::map_state_type cur,
   output cbm_pkg::map_state_type nxt,
   output logic [CHR_SLOTS-1:0][7:0] chr_low,
   output logic [CHR_SLOTS-1:0]      chr_high
);

   localparam int IDX_W = $clog2(CHR_SLOTS);

   // everything clear except the outer bank
   localparam cbm_pkg::map_state_type STATE_RESET = '{
      chr_ram_mode: 1'b0, chr_shift: 1'b0, prg_swap: 1'b0, mirror: 2'd0,
      outer_bank: 1'b1, prg0: 5'd0, prg1: 5'd0, irq_enable: 1'b0,
      irq_count: 16'd0, irq_pending: 1'b0
   };

   cbm_pkg::map_state_type state_ff, state_in;
   logic [CHR_SLOTS-1:0][7:0] chr_low_ff, chr_low_in;
   logic [CHR_SLOTS-1:0]      chr_high_ff, chr_high_in;

   logic [1:0]       low;
   logic [3:0]       nib;
   logic [1:0]       chr_grp;
   logic [IDX_W-1:0] idx;
   logic [15:0]      sum;

   // fold address bits 7:2 into bits 1:0
   assign low     = item.address[1:0] | item.address[3:2] | item.address[5:4]
                  | item.address[7:6];
   assign nib     = item.address[15:12];
   assign chr_grp = 2'(nib - cbm_pkg::NIB_CHR0);
   assign idx     = IDX_W'({chr_grp, low[1]});
   assign sum     = state_ff.irq_count + {8'd0, item.cycles};

   always_comb begin
      state_in    = state_ff;
      chr_low_in  = chr_low_ff;
      chr_high_in = chr_high_ff;
      if (csr_write) begin
         case (csr_index)
            cbm_pkg::CSR_CHR_RAM_MODE: state_in.chr_ram_mode = csr_wdata;
            cbm_pkg::CSR_CHR_SHIFT:    state_in.chr_shift    = csr_wdata;
            default: ;
         endcase
      end
      if (fire) begin
         case (item.operation)
            cbm_pkg::OP_WRITE: begin
               if (nib inside {[cbm_pkg::NIB_CHR0:cbm_pkg::NIB_CHR3]}) begin
                  if (state_ff.chr_ram_mode) begin
                     state_in.outer_bank = item.data[3];
                  end else if (low[0]) begin
                     chr_low_in[idx][7:4] = item.data[3:0];
                     chr_high_in[idx]     = item.data[4];
                  end else begin
                     chr_low_in[idx][3:0] = item.data[3:0];
                  end
               end else begin
                  case (nib)
                     cbm_pkg::NIB_PRG0: state_in.prg0 = item.data[4:0];
                     cbm_pkg::NIB_PRG1: state_in.prg1 = item.data[4:0];
                     cbm_pkg::NIB_CTRL: begin
                        if (low[1]) begin
                           state_in.prg_swap = item.data[1];
                        end else if (item.data != cbm_pkg::MIRROR_IGNORE) begin
                           state_in.mirror = item.data[1:0];
                        end
                     end
                     cbm_pkg::NIB_IRQ: begin
                        if (low == cbm_pkg::LOW_IRQ_ARM) begin
                           state_in.irq_enable  = 1'b1;
                           state_in.irq_count   = '0;
                           state_in.irq_pending = 1'b0;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            cbm_pkg::OP_TICK: begin
               if (state_ff.irq_enable && item.visible_line) begin
                  state_in.irq_count = sum;
                  if (sum > cbm_pkg::IRQ_LIMIT) begin
                     state_in.irq_enable  = 1'b0;
                     state_in.irq_pending = 1'b1;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= STATE_RESET;
         chr_low_ff  <= '0;
         chr_high_ff <= '0;
      end else begin
         state_ff    <= state_in;
         chr_low_ff  <= chr_low_in;
         chr_high_ff <= chr_high_in;
      end
   end

   assign cur      = state_ff;
   assign nxt      = state_in;
   assign chr_low  = chr_low_ff;
   assign chr_high = chr_high_ff;

endmodule

[rtl/core/cbm_lookup.sv]
// bank lookup for prg and chr addresses
`timescale 1ns / 1ps

module cbm_lookup #(
   parameter int CHR_SLOTS = cbm_pkg::CHR_SLOTS_DEF
) (
   input  cbm_pkg::req_type          item,
   input  cbm_pkg::map_state_type    cur,
   input  logic [CHR_SLOTS-1:0][7:0] chr_low,
   input  logic [CHR_SLOTS-1:0]      chr_high,
   output logic [8:0]                bank
);

   localparam int IDX_W = $clog2(CHR_SLOTS);

   logic [4:0]       prg_b;
   logic [IDX_W-1:0] slot;
   logic [8:0]       chr_b;

   assign slot  = item.address[10 +: IDX_W];
   assign chr_b = {chr_high[slot], chr_low[slot]};

   always_comb begin
      case (item.address[14:13])
         2'd0:    prg_b = cur.prg_swap ? cbm_pkg::PRG_FIXED0 : cur.prg0;
         2'd1:    prg_b = cur.prg1;
         2'd2:    prg_b = cur.prg_swap ? cur.prg0 : cbm_pkg::PRG_FIXED0;
         default: prg_b = cbm_pkg::PRG_FIXED1;
      endcase
   end

   always_comb begin
      case (item.operation)
         cbm_pkg::OP_PRG: begin
            // work ram area answers zero
            bank = item.address[15] ? {3'd0, cur.outer_bank, prg_b} : '0;
         end
         cbm_pkg::OP_CHR: begin
            if (cur.chr_ram_mode) begin
               bank = 9'(slot);
            end else begin
               bank = cur.chr_shift ? {1'b0, chr_b[8:1]} : chr_b;
            end
         end
         default: bank = '0;
      endcase
   end

endmodule
